### hdl/spc_pkg.sv
package spc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_WIDTH     = 32;
  localparam int THR_WIDTH       = 32;
  localparam int THR_FRAC        = 32;
  localparam int PARAM_FRAC      = 16;
  localparam int PARAM_WIDTH     = PARAM_FRAC + 1;
  localparam logic [PARAM_WIDTH-1:0] PARAM_ONE = PARAM_WIDTH'(1) << PARAM_FRAC;
  localparam logic [THR_WIDTH-1:0]   THR_RESET = THR_WIDTH'(512);

  // dot products: (CW+1)x(CW+1) products, three summed, plus headroom
  localparam int WW  = 2 * COORD_WIDTH + 6;
  localparam int HW  = WW / 2;
  localparam int PW  = 2 * WW;
  localparam int XW  = PW + THR_FRAC;

  localparam int PIPE_LAT = 46;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] seg1_start_x;
    logic signed [COORD_WIDTH-1:0] seg1_start_y;
    logic signed [COORD_WIDTH-1:0] seg1_start_z;
    logic signed [COORD_WIDTH-1:0] seg1_end_x;
    logic signed [COORD_WIDTH-1:0] seg1_end_y;
    logic signed [COORD_WIDTH-1:0] seg1_end_z;
    logic signed [COORD_WIDTH-1:0] seg2_start_x;
    logic signed [COORD_WIDTH-1:0] seg2_start_y;
    logic signed [COORD_WIDTH-1:0] seg2_start_z;
    logic signed [COORD_WIDTH-1:0] seg2_end_x;
    logic signed [COORD_WIDTH-1:0] seg2_end_y;
    logic signed [COORD_WIDTH-1:0] seg2_end_z;
  } spc_in_t;

  typedef struct packed {
    logic [PARAM_WIDTH-1:0] param_first;
    logic [PARAM_WIDTH-1:0] param_second;
  } spc_out_t;

  typedef struct packed {
    logic signed [WW-1:0] a;
    logic signed [WW-1:0] b;
    logic signed [WW-1:0] c;
    logic signed [WW-1:0] e;
    logic signed [WW-1:0] f;
    logic                 deg_a;
    logic                 deg_e;
  } spc_dot_t;

  // x carries frac_bits fraction bits, thr is unsigned Q0.32
  function automatic logic at_most_thr(input logic signed [PW-1:0] x,
                                       input logic [THR_WIDTH-1:0] thr,
                                       input int frac_bits);
    logic signed [XW-1:0] lhs;
    logic signed [XW-1:0] rhs;
    lhs = XW'(x) <<< THR_FRAC;
    rhs = $signed(XW'(thr) << frac_bits);
    return lhs <= rhs;
  endfunction

endpackage

### hdl/segment_pair_closest_params.sv
// Closest-point parameters of two 3D segments.
// Input: pulse start with a request on in_data (two segments, signed Q16.16
// coordinates). busy is always low, so a request is taken every cycle start
// is high.
// Output: out_strobe is high for one cycle with out_data holding s and t,
// unsigned Q1.16 (65536 is one). The receiver cannot stall; results leave in
// order, one per request.
// Throughput: one request per cycle. The depth is set by the two 16-stage
// restoring dividers (general-case s, then the final quotient), the dot
// product stages, the split wide multipliers ahead of the first divider and
// the one between the dividers.
// Configuration: cfg_we with cfg_wdata writes the degenerate threshold
// (unsigned Q0.32). Write only while no request is in flight.
// Reset: clears all valid bits and loads the threshold with 512.
module segment_pair_closest_params (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  spc_pkg::spc_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [spc_pkg::THR_WIDTH-1:0] cfg_wdata,
  output logic                          out_strobe,
  output spc_pkg::spc_out_t             out_data
);
  import spc_pkg::*;

  localparam int CTX_LEN = 24;
  localparam int TAP_BS  = 20;
  localparam int TAP_T   = 22;
  localparam int TAP_SEL = 23;
  localparam int MDL_LEN = 17;

  typedef struct packed {
    logic                   s_q;
    logic                   t_q;
    logic [PARAM_WIDTH-1:0] s_fix;
    logic [PARAM_WIDTH-1:0] t_fix;
  } mode_t;

  logic [THR_WIDTH-1:0]   thr_r;
  logic [PIPE_LAT:1]      vld_r;
  spc_dot_t               dots;
  spc_dot_t               ctx_r [0:CTX_LEN-1];
  logic signed [PW-1:0]   ae, bb, bf, ce, bs;
  logic signed [PW-1:0]   d_r, n_r, num1_r, den1_r;
  logic [PARAM_WIDTH-1:0] q1, q2;
  logic [PARAM_WIDTH-1:0] s0_r [0:2];
  logic signed [PW-1:0]   t_r, eh_r;
  logic signed [PW-1:0]   num2_r, den2_r, num2_nxt, den2_nxt;
  mode_t                  mode_r, mode_nxt;
  mode_t                  mdl_r [0:MDL_LEN-1];
  spc_out_t               out_r;
  spc_dot_t               cx;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      vld_r <= {vld_r[PIPE_LAT-1:1], start & ~busy};
    end
  end

  spc_dots u_dots (.clk(clk), .seg(in_data), .thr(thr_r), .dots(dots));

  spc_wmul u_ae (.clk(clk), .op_a(dots.a), .op_b(dots.e), .prod(ae));
  spc_wmul u_bb (.clk(clk), .op_a(dots.b), .op_b(dots.b), .prod(bb));
  spc_wmul u_bf (.clk(clk), .op_a(dots.b), .op_b(dots.f), .prod(bf));
  spc_wmul u_ce (.clk(clk), .op_a(dots.c), .op_b(dots.e), .prod(ce));

  always_ff @(posedge clk) begin
    ctx_r[0] <= dots;
    for (int k = 1; k < CTX_LEN; k++) begin
      ctx_r[k] <= ctx_r[k-1];
    end
    d_r    <= ae - bb;
    n_r    <= bf - ce;
    // parallel segments: force s to zero
    num1_r <= at_most_thr(d_r, thr_r, 4 * COORD_FRAC_BITS) ? '0 : n_r;
    den1_r <= d_r;
  end

  spc_div u_div_s (.clk(clk), .num(num1_r), .den(den1_r), .quo(q1));

  spc_wmul u_bs (
    .clk (clk),
    .op_a(ctx_r[TAP_BS].b),
    .op_b($signed(WW'(q1))),
    .prod(bs)
  );

  always_ff @(posedge clk) begin
    s0_r[0] <= q1;
    s0_r[1] <= s0_r[0];
    s0_r[2] <= s0_r[1];
    t_r     <= bs + (PW'(ctx_r[TAP_T].f) <<< PARAM_FRAC);
    eh_r    <= PW'(ctx_r[TAP_T].e) <<< PARAM_FRAC;
  end

  assign cx = ctx_r[TAP_SEL];

  // pick the remaining quotient, if any, and the fixed side
  always_comb begin
    num2_nxt = '0;
    den2_nxt = PW'(1);
    mode_nxt = '{s_q: 1'b0, t_q: 1'b0, s_fix: '0, t_fix: '0};
    if (cx.deg_a && cx.deg_e) begin
      num2_nxt = '0;
    end else if (cx.deg_a) begin
      mode_nxt.t_q = 1'b1;
      num2_nxt     = PW'(cx.f);
      den2_nxt     = PW'(cx.e);
    end else if (cx.deg_e || t_r < 0) begin
      mode_nxt.s_q = 1'b1;
      num2_nxt     = -PW'(cx.c);
      den2_nxt     = PW'(cx.a);
    end else if (t_r > eh_r) begin
      mode_nxt.s_q   = 1'b1;
      mode_nxt.t_fix = PARAM_ONE;
      num2_nxt       = PW'(cx.b) - PW'(cx.c);
      den2_nxt       = PW'(cx.a);
    end else begin
      mode_nxt.t_q   = 1'b1;
      mode_nxt.s_fix = s0_r[2];
      num2_nxt       = t_r;
      den2_nxt       = eh_r;
    end
  end

  always_ff @(posedge clk) begin
    num2_r   <= num2_nxt;
    den2_r   <= den2_nxt;
    mode_r   <= mode_nxt;
    mdl_r[0] <= mode_r;
    for (int k = 1; k < MDL_LEN; k++) begin
      mdl_r[k] <= mdl_r[k-1];
    end
  end

  spc_div u_div_f (.clk(clk), .num(num2_r), .den(den2_r), .quo(q2));

  always_ff @(posedge clk) begin
    out_r.param_first  <= mdl_r[MDL_LEN-1].s_q ? q2 : mdl_r[MDL_LEN-1].s_fix;
    out_r.param_second <= mdl_r[MDL_LEN-1].t_q ? q2 : mdl_r[MDL_LEN-1].t_fix;
  end

  assign out_strobe = vld_r[PIPE_LAT];
  assign out_data   = out_r;

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.param_first <= PARAM_ONE) &&
                   (out_data.param_second <= PARAM_ONE))
    else $error("parameter out of range");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("result missing after pipeline latency");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe after reset");

endmodule

### hdl/spc_wmul.sv
module spc_wmul (
  input  logic                        clk,
  input  logic signed [spc_pkg::WW-1:0] op_a,
  input  logic signed [spc_pkg::WW-1:0] op_b,
  output logic signed [spc_pkg::PW-1:0] prod
);
  import spc_pkg::*;

  logic signed [HW-1:0]   a_hi, b_hi;
  logic signed [HW:0]     a_lo, b_lo;
  logic signed [2*HW-1:0] hh_r;
  logic signed [2*HW:0]   hl_r, lh_r;
  logic [2*HW-1:0]        ll_r;
  logic signed [PW-1:0]   prod_r;

  assign a_hi = op_a[WW-1:HW];
  assign b_hi = op_b[WW-1:HW];
  assign a_lo = $signed({1'b0, op_a[HW-1:0]});
  assign b_lo = $signed({1'b0, op_b[HW-1:0]});

  // partial products, then the aligned sum
  always_ff @(posedge clk) begin
    hh_r   <= a_hi * b_hi;
    hl_r   <= a_hi * b_lo;
    lh_r   <= a_lo * b_hi;
    ll_r   <= op_a[HW-1:0] * op_b[HW-1:0];
    prod_r <= (PW'(hh_r) <<< (2 * HW)) + ((PW'(hl_r) + PW'(lh_r)) <<< HW)
              + $signed(PW'(ll_r));
  end

  assign prod = prod_r;

endmodule

### hdl/spc_div.sv
module spc_div (
  input  logic                          clk,
  input  logic signed [spc_pkg::PW-1:0] num,
  input  logic signed [spc_pkg::PW-1:0] den,
  output logic [spc_pkg::PARAM_WIDTH-1:0] quo
);
  import spc_pkg::*;

  localparam int STEPS = PARAM_FRAC;

  logic [PW-1:0]         rem_r  [0:STEPS];
  logic [PW-1:0]         den_r  [0:STEPS];
  logic [STEPS-1:0]      q_r    [0:STEPS];
  logic                  zero_r [0:STEPS];
  logic                  one_r  [0:STEPS];
  logic [PW-1:0]         rem_nxt [1:STEPS];
  logic                  bit_nxt [1:STEPS];

  always_comb begin
    logic [PW:0] r2;
    for (int k = 1; k <= STEPS; k++) begin
      r2 = {rem_r[k-1], 1'b0};
      bit_nxt[k] = r2 >= {1'b0, den_r[k-1]};
      rem_nxt[k] = bit_nxt[k] ? PW'(r2 - {1'b0, den_r[k-1]}) : PW'(r2);
    end
  end

  // one quotient bit per stage
  always_ff @(posedge clk) begin
    rem_r[0]  <= num;
    den_r[0]  <= den;
    q_r[0]    <= '0;
    zero_r[0] <= (den <= 0) || (num <= 0);
    one_r[0]  <= num >= den;
    for (int k = 1; k <= STEPS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      den_r[k]  <= den_r[k-1];
      q_r[k]    <= {q_r[k-1][STEPS-2:0], bit_nxt[k]};
      zero_r[k] <= zero_r[k-1];
      one_r[k]  <= one_r[k-1];
    end
  end

  assign quo = zero_r[STEPS] ? '0 :
               one_r[STEPS]  ? PARAM_ONE : {1'b0, q_r[STEPS]};

endmodule

### hdl/spc_dots.sv
module spc_dots (
  input  logic                          clk,
  input  spc_pkg::spc_in_t              seg,
  input  logic [spc_pkg::THR_WIDTH-1:0] thr,
  output spc_pkg::spc_dot_t             dots
);
  import spc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = 2 * DW;

  logic signed [DW-1:0] d1_r [0:2];
  logic signed [DW-1:0] d2_r [0:2];
  logic signed [DW-1:0] r_r  [0:2];
  logic signed [MW-1:0] paa_r [0:2];
  logic signed [MW-1:0] pee_r [0:2];
  logic signed [MW-1:0] pbb_r [0:2];
  logic signed [MW-1:0] pcc_r [0:2];
  logic signed [MW-1:0] pff_r [0:2];
  logic signed [WW-1:0] a_sum, e_sum;
  spc_dot_t             dots_r;

  always_ff @(posedge clk) begin
    d1_r[0] <= DW'(seg.seg1_end_x) - DW'(seg.seg1_start_x);
    d1_r[1] <= DW'(seg.seg1_end_y) - DW'(seg.seg1_start_y);
    d1_r[2] <= DW'(seg.seg1_end_z) - DW'(seg.seg1_start_z);
    d2_r[0] <= DW'(seg.seg2_end_x) - DW'(seg.seg2_start_x);
    d2_r[1] <= DW'(seg.seg2_end_y) - DW'(seg.seg2_start_y);
    d2_r[2] <= DW'(seg.seg2_end_z) - DW'(seg.seg2_start_z);
    r_r[0]  <= DW'(seg.seg1_start_x) - DW'(seg.seg2_start_x);
    r_r[1]  <= DW'(seg.seg1_start_y) - DW'(seg.seg2_start_y);
    r_r[2]  <= DW'(seg.seg1_start_z) - DW'(seg.seg2_start_z);
    for (int k = 0; k < 3; k++) begin
      paa_r[k] <= d1_r[k] * d1_r[k];
      pee_r[k] <= d2_r[k] * d2_r[k];
      pbb_r[k] <= d1_r[k] * d2_r[k];
      pcc_r[k] <= d1_r[k] * r_r[k];
      pff_r[k] <= d2_r[k] * r_r[k];
    end
  end

  assign a_sum = WW'(paa_r[0]) + WW'(paa_r[1]) + WW'(paa_r[2]);
  assign e_sum = WW'(pee_r[0]) + WW'(pee_r[1]) + WW'(pee_r[2]);

  always_ff @(posedge clk) begin
    dots_r.a     <= a_sum;
    dots_r.e     <= e_sum;
    dots_r.b     <= WW'(pbb_r[0]) + WW'(pbb_r[1]) + WW'(pbb_r[2]);
    dots_r.c     <= WW'(pcc_r[0]) + WW'(pcc_r[1]) + WW'(pcc_r[2]);
    dots_r.f     <= WW'(pff_r[0]) + WW'(pff_r[1]) + WW'(pff_r[2]);
    dots_r.deg_a <= at_most_thr(PW'(a_sum), thr, 2 * COORD_FRAC_BITS);
    dots_r.deg_e <= at_most_thr(PW'(e_sum), thr, 2 * COORD_FRAC_BITS);
  end

  assign dots = dots_r;

endmodule

### dv/spc_checker.sv
module spc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  spc_pkg::spc_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [spc_pkg::THR_WIDTH-1:0] cfg_wdata,
  input  logic                          out_strobe,
  input  spc_pkg::spc_out_t             out_data,
  output int                            fail_count,
  output int                            pending_count,
  output int                            checked_count
);
  import spc_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic [THR_WIDTH-1:0] thr_shadow;
  spc_out_t             params_q[$];

  function automatic logic below_thr(input wide_t x, input logic [THR_WIDTH-1:0] thr,
                                     input int frac);
    wide_t lhs;
    wide_t rhs;
    lhs = x <<< 32;
    rhs = $signed({224'd0, thr}) <<< frac;
    return lhs <= rhs;
  endfunction

  function automatic logic [PARAM_WIDTH-1:0] quot_q16(input wide_t num, input wide_t den);
    wide_t q;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return PARAM_ONE;
    q = (num <<< 16) / den;
    return q[PARAM_WIDTH-1:0];
  endfunction

  function automatic wide_t dot(input wide_t u[3], input wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic spc_out_t closest_params(input spc_in_t p,
                                              input logic [THR_WIDTH-1:0] thr);
    wide_t d1[3];
    wide_t d2[3];
    wide_t r[3];
    wide_t c[12];
    wide_t a, e, f, cc, b, den, tn, eh;
    logic [PARAM_WIDTH-1:0] s, t;
    logic deg_a, deg_e;
    spc_out_t o;
    c = '{p.seg1_start_x, p.seg1_start_y, p.seg1_start_z,
          p.seg1_end_x, p.seg1_end_y, p.seg1_end_z,
          p.seg2_start_x, p.seg2_start_y, p.seg2_start_z,
          p.seg2_end_x, p.seg2_end_y, p.seg2_end_z};
    for (int k = 0; k < 3; k++) begin
      d1[k] = c[3+k] - c[k];
      d2[k] = c[9+k] - c[6+k];
      r[k]  = c[k] - c[6+k];
    end
    a = dot(d1, d1);
    e = dot(d2, d2);
    f = dot(d2, r);
    cc = dot(d1, r);
    b = dot(d1, d2);
    deg_a = below_thr(a, thr, 32);
    deg_e = below_thr(e, thr, 32);
    s = '0;
    t = '0;
    if (deg_a && deg_e) begin
      s = '0;
    end else if (deg_a) begin
      t = quot_q16(f, e);
    end else if (deg_e) begin
      s = quot_q16(-cc, a);
    end else begin
      den = a * e - b * b;
      s = below_thr(den, thr, 64) ? '0 : quot_q16(b * f - cc * e, den);
      tn = b * $signed({239'd0, s}) + (f <<< 16);
      eh = e <<< 16;
      if (tn < 0) begin
        t = '0;
        s = quot_q16(-cc, a);
      end else if (tn > eh) begin
        t = PARAM_ONE;
        s = quot_q16(b - cc, a);
      end else begin
        t = quot_q16(tn, eh);
      end
    end
    o.param_first = s;
    o.param_second = t;
    return o;
  endfunction

  assign pending_count = params_q.size();

  always @(posedge clk) begin
    spc_out_t want;
    int errs;
    if (!rst_n) begin
      thr_shadow <= THR_RESET;
      fail_count <= 0;
      checked_count <= 0;
      params_q.delete();
    end else begin
      errs = 0;
      if (cfg_we) thr_shadow <= cfg_wdata;
      if (out_strobe) begin
        if (params_q.size() == 0) begin
          $display("%0t: unexpected result s=%0d t=%0d", $time,
                   out_data.param_first, out_data.param_second);
          errs++;
        end else begin
          want = params_q.pop_front();
          checked_count <= checked_count + 1;
          if (want.param_first !== out_data.param_first) begin
            $display("%0t: param_first expected %0d actual %0d", $time,
                     want.param_first, out_data.param_first);
            errs++;
          end
          if (want.param_second !== out_data.param_second) begin
            $display("%0t: param_second expected %0d actual %0d", $time,
                     want.param_second, out_data.param_second);
            errs++;
          end
        end
      end
      if (start && !busy) params_q.push_back(closest_params(in_data, thr_shadow));
      fail_count <= fail_count + errs;
    end
  end
endmodule

### dv/testbench.sv
module testbench;
  import spc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  spc_in_t              in_data = '0;
  logic                 cfg_we = 1'b0;
  logic [THR_WIDTH-1:0] cfg_wdata = '0;
  logic                 out_strobe;
  spc_out_t             out_data;
  int                   fail_count, pending_count, checked_count;
  int                   n_sent = 0;
  logic                 calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  segment_pair_closest_params u_top (
    .clk, .rst_n, .start, .busy, .in_data, .cfg_we, .cfg_wdata, .out_strobe, .out_data
  );

  spc_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_data, .cfg_we, .cfg_wdata, .out_strobe, .out_data,
    .fail_count, .pending_count, .checked_count
  );

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 8191)) - 4096;
      2: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $signed($urandom_range(0, 65536 * 64)) - 65536 * 32;
    endcase
  endfunction

  function automatic spc_in_t rand_pair();
    spc_in_t p;
    int mode;
    logic signed [31:0] k;
    mode = $urandom_range(0, 3);
    p = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    case ($urandom_range(0, 9))
      0: {p.seg1_end_x, p.seg1_end_y, p.seg1_end_z} =
         {p.seg1_start_x, p.seg1_start_y, p.seg1_start_z};
      1: {p.seg2_end_x, p.seg2_end_y, p.seg2_end_z} =
         {p.seg2_start_x, p.seg2_start_y, p.seg2_start_z};
      2: begin
        // parallel: second direction a multiple of the first
        k = $urandom_range(0, 4) - 2;
        p.seg2_end_x = p.seg2_start_x + k * (p.seg1_end_x - p.seg1_start_x);
        p.seg2_end_y = p.seg2_start_y + k * (p.seg1_end_y - p.seg1_start_y);
        p.seg2_end_z = p.seg2_start_z + k * (p.seg1_end_z - p.seg1_start_z);
      end
      3: p.seg1_end_x = p.seg1_start_x + $signed($urandom_range(0, 2)) - 1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send(input spc_in_t p);
    if (!calm) begin
      while ($urandom_range(0, 99) < 6) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_and_write(input logic [THR_WIDTH-1:0] thr);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [THR_WIDTH-1:0] thr_list[5];
    thr_list = '{32'd0, 32'hFFFF_FFFF, 32'd512, 32'd1, 32'h0001_0000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, degenerate, parallel, clamping
    send('0);
    send('1);
    send({12{32'sh7FFF_FFFF}});
    send({12{32'sh8000_0000}});
    send({32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send({96'd0, 32'sd65536, 64'd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd131072, 32'sd0});
    send({96'd0, 32'sd65536, 64'd0, 96'd0, 32'sd65536, 64'd0});
    send({96'd0, 96'd0, 32'sd65536, 64'd0, 32'sd131072, 64'd0});
    send({96'd0, 32'sd65536, 64'd0, 32'sd196608, 64'd0, 32'sd196608, 64'd0});
    send({96'd0, 32'sd65536, 64'd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0});
    send({96'd0, 32'sd65536, 64'd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd131072, 32'sd65536, 32'sd0});
    send({96'd0, 32'sd65536, 64'd0, -32'sd131072, 32'sd65536, 32'sd0, -32'sd65536, -32'sd65536, 32'sd0});
    send({96'd0, 32'sd1, 64'd0, 96'd0, 32'sd0, 32'sd1, 32'sd0});
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_write(thr_list[ph]);
      calm = (ph == 2);
      for (int i = 0; i < 210; i++) begin
        send(rand_pair());
        if (ph == 1 && i == 100) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("Sent %0d segment pairs over 6 threshold settings, %0d results checked.",
             n_sent, checked_count);
    if (fail_count == 0 && pending_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
